// File: hw/rtl/spm_pkg.sv
package spm_pkg;

   // Field and register widths.
   localparam int unsigned TICK_W = 16;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CHAN_W = 3;
   localparam int unsigned PINS_W = 8;
   localparam int unsigned PROD_W = BYTE_W + TICK_W;
   localparam int unsigned CSR_IDX_W = 2;

   // Register reset values.
   localparam logic [TICK_W-1:0] RESET_MIN  = 16'd16000;
   localparam logic [TICK_W-1:0] RESET_SPAN = 16'd16000;
   localparam logic [TICK_W-1:0] RESET_SLOT = 16'd40000;

   // Byte value that maps to the full span.
   localparam logic [BYTE_W-1:0] BYTE_FULL = 8'd255;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_MIN  = 2'd0,
      CSR_PULSE_SPAN = 2'd1,
      CSR_SLOT_TICKS = 2'd2
   } csr_index_type;

   // Input command codes.
   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_BYTE = 1'b1
   } cmd_type;

endpackage

// File: hw/rtl/spm_width_calc.sv
module spm_width_calc (
   input  logic [spm_pkg::PROD_W-1:0] prod,
   input  logic [spm_pkg::TICK_W-1:0] pulse_min,
   output logic [spm_pkg::TICK_W-1:0] width
);
   import spm_pkg::*;

   logic [PROD_W:0]   est_sum;
   logic [PROD_W-8:0] q_est;
   logic [PROD_W:0]   q_times_full;
   logic [PROD_W:0]   rem;
   logic [TICK_W-1:0] quot;
   logic [TICK_W:0]   width_sum;

   // Quotient estimate for prod / 255 from the series 1/256 + 1/256^2 + 1/256^3.
   // The estimate is never high and at most one low.
   assign est_sum = {1'b0, prod} + {9'd0, prod[PROD_W-1:8]} + {17'd0, prod[PROD_W-1:16]};
   assign q_est   = est_sum[PROD_W:8];

   // One compare and subtract corrects the estimate.
   assign q_times_full = {q_est, 8'd0} - {8'd0, q_est};
   assign rem          = {1'b0, prod} - q_times_full;
   assign quot         = (rem >= {{(PROD_W+1-BYTE_W){1'b0}}, BYTE_FULL})
                         ? q_est[TICK_W-1:0] + 1'b1 : q_est[TICK_W-1:0];

   // Add the minimum and saturate at the largest tick count.
   assign width_sum = {1'b0, pulse_min} + {1'b0, quot};
   assign width     = width_sum[TICK_W] ? {TICK_W{1'b1}} : width_sum[TICK_W-1:0];

endmodule

// File: hw/rtl/servo_pulse_multiplexer_core.sv
// An accepted word is held in the input register, then moves to the result register.
// Throughput: one word per cycle while the result is not stalled; a stalled result
// still lets one more word in.
// Byte words set one entry of the pulse width table, tick words step the slot timer.
// Reset: synchronous, active high; it restores the register defaults, fills the
// width table with 16000 ticks and clears the slot timer, channel counters and held pins.
module servo_pulse_multiplexer_core #(
   parameter int unsigned CHANNELS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [spm_pkg::BYTE_W-1:0]    req_position_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [spm_pkg::PINS_W-1:0]    rsp_servo_pins,
   output logic [spm_pkg::CHAN_W-1:0]    rsp_active_channel,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [spm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spm_pkg::TICK_W-1:0]    csr_wdata
);
   import spm_pkg::*;

   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(CHANNELS - 1);

   // Configuration registers.
   logic [TICK_W-1:0] pulse_min_ff,  pulse_min_in;
   logic [TICK_W-1:0] pulse_span_ff, pulse_span_in;
   logic [TICK_W-1:0] slot_ticks_ff, slot_ticks_in;

   // Input stage.
   logic              a_valid_ff, a_valid_in;
   logic              a_cmd_ff;
   logic [PROD_W-1:0] a_prod_ff;

   // Block state.
   logic [TICK_W-1:0] table_ff [CHANNELS];
   logic [IDX_W-1:0]  write_ch_ff, write_ch_in;
   logic [IDX_W-1:0]  slot_ch_ff, slot_ch_in;
   logic [TICK_W-1:0] slot_pos_ff, slot_pos_in;
   logic [TICK_W-1:0] latched_ff, latched_in;
   logic [PINS_W-1:0] held_pins_ff, held_pins_in;

   // Result stage.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PINS_W-1:0] rsp_pins_ff, rsp_pins_in;
   logic [IDX_W-1:0]  rsp_ch_ff, rsp_ch_in;

   logic              req_take;
   logic              out_free;
   logic              a_go;
   logic              is_byte;
   logic              is_tick;
   logic [TICK_W-1:0] new_width;
   logic [TICK_W-1:0] cur_width;
   logic [TICK_W:0]   pos_next;
   logic              slot_end;
   logic [PINS_W-1:0] ch_pin;

   // Handshake control: the input stage moves on when the result register is free.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign a_go      = a_valid_ff && out_free;
   assign req_stall = a_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign a_valid_in   = req_take ? 1'b1 : (a_go ? 1'b0 : a_valid_ff);
   assign rsp_valid_in = out_free ? a_valid_ff : rsp_valid_ff;

   // Configuration writes; unknown indexes are dropped.
   always_comb begin
      pulse_min_in  = pulse_min_ff;
      pulse_span_in = pulse_span_ff;
      slot_ticks_in = slot_ticks_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PULSE_MIN:  pulse_min_in  = csr_wdata;
            CSR_PULSE_SPAN: pulse_span_in = csr_wdata;
            CSR_SLOT_TICKS: slot_ticks_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Width from a received byte.
   spm_width_calc u_width_calc (
      .prod      (a_prod_ff),
      .pulse_min (pulse_min_ff),
      .width     (new_width)
   );

   assign is_byte = a_go && (a_cmd_ff == CMD_BYTE);
   assign is_tick = a_go && (a_cmd_ff == CMD_TICK);

   // Slot timer: latch the width at slot start, drive the pin, advance the slot.
   assign cur_width = (slot_pos_ff == '0) ? table_ff[slot_ch_ff] : latched_ff;
   assign pos_next  = {1'b0, slot_pos_ff} + 1'b1;
   assign slot_end  = (pos_next >= {1'b0, slot_ticks_ff});
   assign ch_pin    = PINS_W'(1) << slot_ch_ff;

   always_comb begin
      write_ch_in  = write_ch_ff;
      slot_ch_in   = slot_ch_ff;
      slot_pos_in  = slot_pos_ff;
      latched_in   = latched_ff;
      held_pins_in = held_pins_ff;
      rsp_pins_in  = rsp_pins_ff;
      rsp_ch_in    = rsp_ch_ff;
      if (is_byte) begin
         write_ch_in = (write_ch_ff == LAST_CH) ? '0 : write_ch_ff + 1'b1;
         rsp_pins_in = held_pins_ff;
         rsp_ch_in   = slot_ch_ff;
      end
      if (is_tick) begin
         latched_in   = cur_width;
         held_pins_in = (slot_pos_ff < cur_width) ? ch_pin : '0;
         rsp_pins_in  = held_pins_in;
         rsp_ch_in    = slot_ch_ff;
         if (slot_end) begin
            slot_pos_in = '0;
            slot_ch_in  = (slot_ch_ff == LAST_CH) ? '0 : slot_ch_ff + 1'b1;
         end else begin
            slot_pos_in = pos_next[TICK_W-1:0];
         end
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff  <= RESET_MIN;
         pulse_span_ff <= RESET_SPAN;
         slot_ticks_ff <= RESET_SLOT;
         a_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         write_ch_ff   <= '0;
         slot_ch_ff    <= '0;
         slot_pos_ff   <= '0;
         latched_ff    <= '0;
         held_pins_ff  <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            table_ff[i] <= RESET_MIN;
         end
      end else begin
         pulse_min_ff  <= pulse_min_in;
         pulse_span_ff <= pulse_span_in;
         slot_ticks_ff <= slot_ticks_in;
         a_valid_ff    <= a_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         write_ch_ff   <= write_ch_in;
         slot_ch_ff    <= slot_ch_in;
         slot_pos_ff   <= slot_pos_in;
         latched_ff    <= latched_in;
         held_pins_ff  <= held_pins_in;
         if (is_byte) begin
            table_ff[write_ch_ff] <= new_width;
         end
      end
   end

   // Payload registers: the input word with its scaled product, and the result.
   always_ff @(posedge clock) begin
      if (req_take) begin
         a_cmd_ff  <= req_cmd;
         a_prod_ff <= req_position_byte * pulse_span_ff;
      end
      rsp_pins_ff <= rsp_pins_in;
      rsp_ch_ff   <= rsp_ch_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_servo_pins     = rsp_pins_ff;
   assign rsp_active_channel = CHAN_W'(rsp_ch_ff);

endmodule
